>>> rtl/core/clipped_box_blur_rgb_defines.svh
// Assertion helpers for the box blur core.
`ifndef CLIPPED_BOX_BLUR_RGB_DEFINES_SVH
`define CLIPPED_BOX_BLUR_RGB_DEFINES_SVH

// same-cycle implication
`define CLB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CLB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/clb_pkg.sv
package clb_pkg;

  localparam int PIX_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  typedef logic [7:0] chan_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

endpackage

>>> rtl/core/clb_line_mem.sv
module clb_line_mem #(
  parameter int DEPTH = 15360,
  parameter int AW = 14
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [clb_pkg::PIX_W-1:0] wr_data,
  input  logic [AW-1:0]           rd_addr,
  output logic [clb_pkg::PIX_W-1:0] rd_data
);
  import clb_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/clb_div.sv
module clb_div #(
  parameter int SW = 16,
  parameter int CW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [2:0][SW-1:0]        num,
  input  logic [CW-1:0]             den,
  output clb_pkg::chan_t [2:0]      quo,
  output logic                      done
);
  import clb_pkg::*;

  localparam int KW = $clog2(SW + 1);

  logic [2:0][SW-1:0] n;
  logic [2:0][CW-1:0] rm;
  logic [2:0][SW-1:0] n_next;
  logic [2:0][CW-1:0] rm_next;
  logic [CW-1:0]      d;
  logic [KW-1:0]      steps;
  logic               busy;

  always_comb begin
    logic [CW:0] t;
    logic        ge;
    for (int ch = 0; ch < 3; ch++) begin
      t = {rm[ch], n[ch][SW-1]};
      ge = (t >= {1'b0, d});
      rm_next[ch] = ge ? CW'(t - {1'b0, d}) : CW'(t);
      n_next[ch] = {n[ch][SW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= KW'(SW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == KW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n <= num;
      rm <= '0;
      d <= den;
    end else if (busy) begin
      n <= n_next;
      rm <= rm_next;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      quo[ch] = n[ch][7:0];
    end
  end

endmodule

>>> rtl/core/clipped_box_blur_rgb.sv
// Channel  Dir  Beat contents
// cfg      in   cfg_index, cfg_data (radius, width, height)
// in       in   pixel_red, pixel_green, pixel_blue, is_filler
// out      out  mean_red, mean_green, mean_blue, frame_last
//
// One input beat per pass: accept and line memory write, readiness check, window reads one
// pixel a cycle over the clipped rows x cols, drain, divider start, divider wait and
// hand-off, which waits while an earlier result is still held on out.
// A beat with no ready result returns to idle from the readiness check.
// Synchronous reset; line memory is not cleared. in_ready is low while cfg_valid is high.
// A result waiting on out does not block the next input beat until the next result is due.
module clipped_box_blur_rgb #(
  parameter int MAX_RADIUS = 7,
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [clb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    pixel_red,
  input  logic [7:0]                    pixel_green,
  input  logic [7:0]                    pixel_blue,
  input  logic                          is_filler,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    mean_red,
  output logic [7:0]                    mean_green,
  output logic [7:0]                    mean_blue,
  output logic                          frame_last
);
  import clb_pkg::*;
  `include "clipped_box_blur_rgb_defines.svh"

  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int SPAN = 2 * MAX_RADIUS + 1;
  localparam int SPW = $clog2(SPAN + 1);
  localparam int CW = $clog2(SPAN * SPAN + 1);
  localparam int SW = $clog2(SPAN * SPAN * 255 + 1);
  // one spare row: the next row's writes overlap window reads at a row end
  localparam int DEPTH = (SPAN + 1) * MAX_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int CB = $clog2(MAX_WIDTH);
  localparam int RB = $clog2(MAX_HEIGHT);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_READ  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_DIVGO = 7'b0010000,
    S_DIVW  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t st;

  logic [2:0]  cfg_radius;
  logic [10:0] cfg_width;
  logic [12:0] cfg_height;

  logic [RW-1:0] rad_e;
  logic [CB:0]   wid_e;
  logic [RB:0]   hgt_e;

  logic [CB-1:0] in_col, out_col;
  logic [RB-1:0] in_row, out_row;
  logic [AW-1:0] in_base, out_base;
  logic          input_done;

  logic [AW-1:0]  rd_base;
  logic [CB-1:0]  rd_col, col_lo, col_hi;
  logic [SPW-1:0] rows_left;
  logic [CW-1:0]  cnt;
  logic [2:0][SW-1:0] sums;
  logic           rd_vld;

  logic          in_acc, cfg_acc, wr_en, out_free;
  logic [PIX_W-1:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [RB:0]   lr_sum;
  logic [CB:0]   lc_sum;
  logic [RB-1:0] last_r, lo_r;
  logic [CB-1:0] last_c, lo_c;
  logic [RW-1:0] dr;
  logic [AW-1:0] back, lo_base;
  logic [SPW-1:0] rspan, cspan;
  logic          ready_now, is_last;

  chan_t [2:0]   quo;
  logic          div_done;

  assign in_acc = in_valid && in_ready;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign in_ready = (st == S_IDLE) && !cfg_valid;
  assign cfg_ready = (st == S_IDLE);
  assign wr_en = in_acc && !is_filler && !input_done;
  assign out_free = !out_valid || out_ready;
  assign rd_addr = rd_base + AW'(rd_col);

  always_comb begin
    rad_e = (int'(cfg_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_radius);
    if (cfg_width == '0) begin
      wid_e = (CB+1)'(1);
    end else if (int'(cfg_width) > MAX_WIDTH) begin
      wid_e = (CB+1)'(MAX_WIDTH);
    end else begin
      wid_e = (CB+1)'(cfg_width);
    end
    if (cfg_height == '0) begin
      hgt_e = (RB+1)'(1);
    end else if (int'(cfg_height) > MAX_HEIGHT) begin
      hgt_e = (RB+1)'(MAX_HEIGHT);
    end else begin
      hgt_e = (RB+1)'(cfg_height);
    end
  end

  always_comb begin
    lr_sum = {1'b0, out_row} + (RB+1)'(rad_e);
    lc_sum = {1'b0, out_col} + (CB+1)'(rad_e);
    last_r = (lr_sum > hgt_e - 1'b1) ? RB'(hgt_e - 1'b1) : RB'(lr_sum);
    last_c = (lc_sum > wid_e - 1'b1) ? CB'(wid_e - 1'b1) : CB'(lc_sum);
    ready_now = input_done || (last_r < in_row) ||
                ((last_r == in_row) && (last_c < in_col));
    lo_r = (out_row >= RB'(rad_e)) ? out_row - RB'(rad_e) : '0;
    lo_c = (out_col >= CB'(rad_e)) ? out_col - CB'(rad_e) : '0;
    dr = RW'(out_row - lo_r);
    back = AW'(dr) * AW'(MAX_WIDTH);
    lo_base = (out_base >= back) ? out_base - back : out_base - back + AW'(DEPTH);
    rspan = SPW'(last_r - lo_r) + SPW'(1);
    cspan = SPW'(last_c - lo_c) + SPW'(1);
    is_last = ({1'b0, out_row} == hgt_e - 1'b1) && ({1'b0, out_col} == wid_e - 1'b1);
  end

  clb_line_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_base + AW'(in_col)),
    .wr_data ({pixel_red, pixel_green, pixel_blue}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  clb_div #(.SW(SW), .CW(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (st == S_DIVGO),
    .num   (sums),
    .den   (cnt),
    .quo   (quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      cfg_radius <= '0;
      cfg_width <= 11'd1024;
      cfg_height <= 13'd4096;
      in_col <= '0;
      in_row <= '0;
      out_col <= '0;
      out_row <= '0;
      in_base <= '0;
      out_base <= '0;
      input_done <= 1'b0;
      rd_vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= (st == S_READ);
      if (st == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (in_acc) begin
            st <= S_CHECK;
            if (wr_en) begin
              if ({1'b0, in_col} + 1'b1 >= wid_e) begin
                in_col <= '0;
                if ({1'b0, in_row} + 1'b1 >= hgt_e) begin
                  in_row <= '0;
                  input_done <= 1'b1;
                end else begin
                  in_row <= in_row + 1'b1;
                end
                if (in_base >= AW'(DEPTH - MAX_WIDTH)) begin
                  in_base <= in_base - AW'(DEPTH - MAX_WIDTH);
                end else begin
                  in_base <= in_base + AW'(MAX_WIDTH);
                end
              end else begin
                in_col <= in_col + 1'b1;
              end
            end
          end
        end
        S_CHECK: begin
          st <= ready_now ? S_READ : S_IDLE;
          rd_base <= lo_base;
          rd_col <= lo_c;
          rows_left <= rspan;
        end
        S_READ: begin
          if (rd_col == col_hi) begin
            rd_col <= col_lo;
            rows_left <= rows_left - 1'b1;
            if (rd_base >= AW'(DEPTH - MAX_WIDTH)) begin
              rd_base <= rd_base - AW'(DEPTH - MAX_WIDTH);
            end else begin
              rd_base <= rd_base + AW'(MAX_WIDTH);
            end
            if (rows_left == SPW'(1)) begin
              st <= S_DRAIN;
            end
          end else begin
            rd_col <= rd_col + 1'b1;
          end
        end
        S_DRAIN: st <= S_DIVGO;
        S_DIVGO: st <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            st <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            st <= S_IDLE;
            if (is_last) begin
              in_col <= '0;
              in_row <= '0;
              out_col <= '0;
              out_row <= '0;
              in_base <= '0;
              out_base <= '0;
              input_done <= 1'b0;
            end else if ({1'b0, out_col} + 1'b1 >= wid_e) begin
              out_col <= '0;
              out_row <= out_row + 1'b1;
              if (out_base >= AW'(DEPTH - MAX_WIDTH)) begin
                out_base <= out_base - AW'(DEPTH - MAX_WIDTH);
              end else begin
                out_base <= out_base + AW'(MAX_WIDTH);
              end
            end else begin
              out_col <= out_col + 1'b1;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
      if (cfg_acc && (cfg_idx_t'(cfg_index) != CFG_NONE)) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RADIUS: cfg_radius <= cfg_data[2:0];
          CFG_WIDTH:  cfg_width <= cfg_data[10:0];
          CFG_HEIGHT: cfg_height <= cfg_data;
          default: ;
        endcase
        in_col <= '0;
        in_row <= '0;
        out_col <= '0;
        out_row <= '0;
        in_base <= '0;
        out_base <= '0;
        input_done <= 1'b0;
      end
    end
  end

  // window setup, accumulation and output data
  always_ff @(posedge clk) begin
    if (st == S_CHECK) begin
      col_lo <= lo_c;
      col_hi <= last_c;
      cnt <= CW'(rspan) * CW'(cspan);
      sums <= '0;
    end else if (rd_vld) begin
      sums[2] <= sums[2] + SW'(rd_data[23:16]);
      sums[1] <= sums[1] + SW'(rd_data[15:8]);
      sums[0] <= sums[0] + SW'(rd_data[7:0]);
    end
    if (st == S_OUT && out_free) begin
      mean_red <= quo[2];
      mean_green <= quo[1];
      mean_blue <= quo[0];
      frame_last <= is_last;
    end
  end

  `CLB_ASSERT_NOW(a_done_pos, clk, rst, input_done, (in_col == '0) && (in_row == '0), "input position not cleared at frame input end")
  `CLB_ASSERT_NOW(a_read_rows, clk, rst, st == S_READ, rows_left != '0, "window read with no rows left")
  `CLB_ASSERT_NOW(a_div_done, clk, rst, div_done, st == S_DIVW, "divider finished outside wait state")
  `CLB_ASSERT_NEXT(a_cnt_nz, clk, rst, st == S_DIVGO, cnt != '0, "zero window count at divide")

endmodule

>>> tb/tb_clipped_box_blur_rgb.sv
`timescale 1ns / 100ps

module tb_clipped_box_blur_rgb;
  import clb_pkg::*;

  localparam int MAX_R = 7;
  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;
  localparam int LINE_DEPTH = (2 * MAX_R + 1) * MAX_W;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_beat_t;

  typedef struct {
    bit          is_cfg;
    cfg_idx_t    idx;
    logic [12:0] data;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    bit          fill;
    bit          typed;
    blur_beat_t  want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic is_filler;
  logic out_valid;
  logic out_ready;
  logic [7:0] mean_red;
  logic [7:0] mean_green;
  logic [7:0] mean_blue;
  logic frame_last;

  clipped_box_blur_rgb i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel_red(pixel_red), .pixel_green(pixel_green), .pixel_blue(pixel_blue),
    .is_filler(is_filler),
    .out_valid(out_valid), .out_ready(out_ready),
    .mean_red(mean_red), .mean_green(mean_green), .mean_blue(mean_blue),
    .frame_last(frame_last)
  );

  // blur model state
  logic [23:0] line_mem [0:LINE_DEPTH-1];
  int unsigned in_col, in_row, out_col, out_row;
  bit frame_in_done;
  int unsigned radius_reg, width_reg, height_reg;

  blur_beat_t mean_q[$];
  stim_row_t stim_rows[$];
  bit failed;
  bit quiet;
  int pixel_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    return (width_reg > MAX_W) ? MAX_W : width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    return (height_reg > MAX_H) ? MAX_H : height_reg;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    frame_in_done = 1'b0;
  endfunction

  function automatic void apply_cfg(cfg_idx_t idx, logic [12:0] d);
    case (idx)
      CFG_RADIUS: radius_reg = d[2:0];
      CFG_WIDTH:  width_reg = d[10:0];
      CFG_HEIGHT: height_reg = d;
      default: return;
    endcase
    restart_frame();
  endfunction

  function automatic bit blur_step(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit fill,
                                   output blur_beat_t res);
    int unsigned rad, w, h, last_r, last_c, lo_r, lo_c, cnt, px;
    int unsigned sr, sg, sb;
    bit ready;
    rad = (radius_reg > MAX_R) ? MAX_R : radius_reg;
    w = eff_width();
    h = eff_height();
    sr = 0;
    sg = 0;
    sb = 0;
    res = '{default: '0};
    if (!fill && !frame_in_done) begin
      line_mem[(in_row * w + in_col) % LINE_DEPTH] = {r, g, b};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          frame_in_done = 1'b1;
        end
      end
    end
    last_r = (out_row + rad > h - 1) ? h - 1 : out_row + rad;
    last_c = (out_col + rad > w - 1) ? w - 1 : out_col + rad;
    ready = frame_in_done || ((last_r * w + last_c) < (in_row * w + in_col));
    if (!ready) return 1'b0;
    lo_r = (out_row >= rad) ? out_row - rad : 0;
    lo_c = (out_col >= rad) ? out_col - rad : 0;
    for (int unsigned i = lo_r; i <= last_r; i++) begin
      for (int unsigned j = lo_c; j <= last_c; j++) begin
        px = 32'(line_mem[(i * w + j) % LINE_DEPTH]);
        sr += px[23:16];
        sg += px[15:8];
        sb += px[7:0];
      end
    end
    cnt = (last_r - lo_r + 1) * (last_c - lo_c + 1);
    res.red = 8'(sr / cnt);
    res.green = 8'(sg / cnt);
    res.blue = 8'(sb / cnt);
    res.last = (out_row == h - 1) && (out_col == w - 1);
    if (res.last) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  function automatic void add_cfg(cfg_idx_t idx, logic [12:0] d);
    stim_row_t row;
    row = '{idx: CFG_RADIUS, default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = d;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_pix(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit fill,
                                  bit typed = 1'b0, logic [7:0] er = 0, logic [7:0] eg = 0,
                                  logic [7:0] eb = 0, logic el = 0);
    stim_row_t row;
    row = '{idx: CFG_RADIUS, default: '0};
    row.red = r;
    row.green = g;
    row.blue = b;
    row.fill = fill;
    row.typed = typed;
    row.want = '{er, eg, eb, el};
    stim_rows.push_back(row);
  endfunction

  task automatic wait_idle();
    while (mean_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [12:0] d);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit fill,
                            bit typed = 1'b0, blur_beat_t want = '{default: '0});
    blur_beat_t res;
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 21) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    pixel_red = r;
    pixel_green = g;
    pixel_blue = b;
    is_filler = fill;
    do @(posedge clk); while (!in_ready);
    if (blur_step(r, g, b, fill, res)) mean_q.push_back(typed ? want : res);
    if (!fill) pixel_count++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  always @(negedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    blur_beat_t exp_beat;
    if (!rst && out_valid && out_ready) begin
      if (mean_q.size() == 0) begin
        $error("unexpected output beat");
        failed = 1'b1;
      end else begin
        exp_beat = mean_q.pop_front();
        if (mean_red !== exp_beat.red) begin
          $error("mean_red exp %0d got %0d", exp_beat.red, mean_red);
          failed = 1'b1;
        end
        if (mean_green !== exp_beat.green) begin
          $error("mean_green exp %0d got %0d", exp_beat.green, mean_green);
          failed = 1'b1;
        end
        if (mean_blue !== exp_beat.blue) begin
          $error("mean_blue exp %0d got %0d", exp_beat.blue, mean_blue);
          failed = 1'b1;
        end
        if (frame_last !== exp_beat.last) begin
          $error("frame_last exp %0d got %0d", exp_beat.last, frame_last);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int unsigned rad, w, h, n;
    int order;
    bit partial;
    failed = 1'b0;
    quiet = 1'b0;
    pixel_count = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_RADIUS;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel_red = '0;
    pixel_green = '0;
    pixel_blue = '0;
    is_filler = 1'b0;
    radius_reg = 0;
    width_reg = 1024;
    height_reg = 4096;
    restart_frame();

    // 1x1 frame: output equals input
    add_cfg(CFG_RADIUS, 13'd0);
    add_cfg(CFG_WIDTH, 13'd1);
    add_cfg(CFG_HEIGHT, 13'd1);
    add_pix(8'hff, 8'h00, 8'haa, 1'b0, 1'b1, 8'hff, 8'h00, 8'haa, 1'b1);
    add_pix(8'h00, 8'hff, 8'h55, 1'b0, 1'b1, 8'h00, 8'hff, 8'h55, 1'b1);
    add_pix(8'h12, 8'h34, 8'h56, 1'b1);
    // pixel after frame input done is dropped
    add_cfg(CFG_RADIUS, 13'd1);
    add_cfg(CFG_WIDTH, 13'd2);
    add_pix(8'hff, 8'hff, 8'hff, 1'b0);
    add_pix(8'h01, 8'h01, 8'h01, 1'b0, 1'b1, 8'd128, 8'd128, 8'd128, 1'b0);
    add_pix(8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd128, 8'd128, 8'd128, 1'b1);
    // unused index: no restart
    add_cfg(CFG_NONE, 13'h1fff);
    // saturating registers, partial frames
    add_cfg(CFG_RADIUS, 13'h1fff);
    add_cfg(CFG_WIDTH, 13'd1);
    add_cfg(CFG_HEIGHT, 13'h1fff);
    for (int i = 0; i < 7; i++) add_pix(8'hff, 8'hff, 8'hff, 1'b0);
    add_pix(8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 8'hff, 8'hff, 8'hff, 1'b0);
    add_pix(8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 8'hff, 8'hff, 8'hff, 1'b0);
    add_cfg(CFG_WIDTH, 13'h7ff);
    add_cfg(CFG_HEIGHT, 13'd0);
    for (int i = 0; i < 9; i++) add_pix(8'h00, 8'h00, 8'h00, 1'b0);
    add_pix(8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_rows[k]) begin
      if (stim_rows[k].is_cfg) begin
        end_burst();
        write_reg(stim_rows[k].idx, stim_rows[k].data);
      end else begin
        send_pixel(stim_rows[k].red, stim_rows[k].green, stim_rows[k].blue,
                   stim_rows[k].fill, stim_rows[k].typed, stim_rows[k].want);
      end
    end
    end_burst();

    pixel_count = 0;
    while (pixel_count < 1600) begin
      quiet = (pixel_count >= 500 && pixel_count < 800);
      partial = ($urandom_range(9) == 0);
      rad = $urandom_range(7);
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 8);
      if (partial) begin
        if ($urandom_range(1)) w = $urandom_range(1025, 2047);
        if ($urandom_range(1)) h = $urandom_range(0, 8191);
        if ($urandom_range(3) == 0) w = 0;
      end
      order = $urandom_range(2);
      end_burst();
      for (int i = 0; i < 3; i++) begin
        case ((i + order) % 3)
          0: write_reg(CFG_RADIUS, 13'({10'($urandom_range(1023)), rad[2:0]}));
          1: write_reg(CFG_WIDTH, 13'(w));
          default: write_reg(CFG_HEIGHT, 13'(h));
        endcase
      end
      if (partial) begin
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
      end else begin
        repeat ($urandom_range(1, 2)) begin
          n = eff_width() * eff_height();
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 8) send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b1);
            send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
          end
          while (frame_in_done) begin
            send_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(99) >= 5);
          end
        end
      end
    end
    quiet = 1'b0;
    end_burst();

    while (mean_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
